// ----- hdl/assert_macros.svh -----
// Assertion helper macros shared by the vertex pool RTL.
// Included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/vdp_pkg.sv -----
// Package for the vertex dedup pool: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps

package vdp_pkg;

    localparam int WORD_W = 32;
    localparam logic [WORD_W-1:0] SIGN_BIT = 32'h8000_0000;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    // One vertex in pool layout.
    typedef struct packed {
        logic [WORD_W-1:0] nx;
        logic [WORD_W-1:0] ny;
        logic [WORD_W-1:0] nz;
        logic [WORD_W-1:0] px;
        logic [WORD_W-1:0] py;
        logic [WORD_W-1:0] pz;
        logic [WORD_W-1:0] u;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] col;
    } vertex_t;

    // IEEE single NaN test.
    function automatic logic is_nan(input logic [WORD_W-1:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    // IEEE single equality: signed zeros equal, NaN equals nothing.
    function automatic logic float_eq(input logic [WORD_W-1:0] a,
                                      input logic [WORD_W-1:0] b);
        logic r;
        if (is_nan(a) || is_nan(b))
            r = 1'b0;
        else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            r = 1'b1;
        else
            r = (a == b);
        return r;
    endfunction

endpackage

// ----- hdl/vertex_dedup_pool.sv -----
// Top level of the vertex dedup pool: pool memory, search sequencer.
// Depends on vdp_pkg, vdp_cmp and assert_macros.svh.
//
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------
// command  | start, busy        | normal_*, pos_*, tex_u, tex_v, colour_word
// result   | done (1-cycle)     | vertex_index, was_added, pool_full, pool_count
//
// An item searches the N entries held; a hit on an entry ends it sooner.
// The single memory read port and the one shared compare unit walk the
// pool one entry at a time (read, then compare). Reset empties the pool
// at once through the entry count; no clearing pass. Results cannot be
// stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vertex_dedup_pool #(
    parameter int POOL_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] normal_x,
    input  logic [31:0] normal_y,
    input  logic [31:0] normal_z,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] tex_u,
    input  logic [31:0] tex_v,
    input  logic [31:0] colour_word,
    output logic        done,
    output logic [7:0]  vertex_index,
    output logic        was_added,
    output logic        pool_full,
    output logic [8:0]  pool_count
);

    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

    vdp_pkg::state_t   state_reg, state_next;
    vdp_pkg::vertex_t  key_reg;
    vdp_pkg::vertex_t  rd_reg;
    vdp_pkg::vertex_t  mem [POOL_DEPTH];
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [7:0]        idx_reg, idx_next;
    logic              added_reg, added_next;
    logic              full_reg, full_next;
    logic              wr_en;
    logic              eq;
    vdp_pkg::vertex_t  key_in;

    // Remap the incoming vertex to left-handed layout; colour_word goes to u, tex_u to v, tex_v to col.
    always_comb
    begin
        key_in.nx  = normal_x;
        key_in.ny  = normal_z ^ vdp_pkg::SIGN_BIT;
        key_in.nz  = normal_y ^ vdp_pkg::SIGN_BIT;
        key_in.px  = pos_x;
        key_in.py  = pos_z ^ vdp_pkg::SIGN_BIT;
        key_in.pz  = pos_y ^ vdp_pkg::SIGN_BIT;
        key_in.u   = colour_word;
        key_in.v   = tex_u;
        key_in.col = tex_v;
    end

    // Pool memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[ptr_reg[AW-1:0]] <= key_reg;
        rd_reg <= mem[ptr_reg[AW-1:0]];
    end

    // Key register loads on an accepted beat.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            key_reg <= key_in;
    end

    vdp_cmp u_cmp (
        .a  (rd_reg),
        .b  (key_reg),
        .eq (eq)
    );

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vdp_pkg::ST_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            idx_reg   <= '0;
            added_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            idx_reg   <= idx_next;
            added_reg <= added_next;
            full_reg  <= full_next;
        end
    end

    // Sequencer: read an entry, compare it, advance or finish.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        added_next = added_reg;
        full_next  = full_reg;
        wr_en      = 1'b0;
        case (state_reg)
            vdp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ptr_next   = '0;
                    state_next = vdp_pkg::ST_READ;
                end
            end
            vdp_pkg::ST_READ:
            begin
                if (ptr_reg == count_reg)
                begin
                    // Miss: append or flag a full pool.
                    if (count_reg == DEPTH_C)
                    begin
                        idx_next   = '0;
                        added_next = 1'b0;
                        full_next  = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        idx_next   = 8'(ptr_reg);
                        added_next = 1'b1;
                        full_next  = 1'b0;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = vdp_pkg::ST_DONE;
                end
                else
                    state_next = vdp_pkg::ST_CMP;
            end
            vdp_pkg::ST_CMP:
            begin
                if (eq)
                begin
                    idx_next   = 8'(ptr_reg);
                    added_next = 1'b0;
                    full_next  = 1'b0;
                    state_next = vdp_pkg::ST_DONE;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = vdp_pkg::ST_READ;
                end
            end
            vdp_pkg::ST_DONE:
                state_next = vdp_pkg::ST_IDLE;
            default:
                state_next = vdp_pkg::ST_IDLE;
        endcase
    end

    assign busy         = (state_reg != vdp_pkg::ST_IDLE);
    assign done         = (state_reg == vdp_pkg::ST_DONE);
    assign vertex_index = idx_reg;
    assign was_added    = added_reg;
    assign pool_full    = full_reg;
    assign pool_count   = 9'(count_reg);

    // The count never passes the depth, and a beat adds at most one entry.
    `ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_reg <= DEPTH_C)
    `ASSERT_NEXT(a_count_step, clk, rst_n, count_reg != count_next, (state_reg == vdp_pkg::ST_DONE) && was_added)
    `ASSERT_IMPL(a_done_flags, clk, rst_n, done, !(was_added && pool_full))
    `ASSERT_IMPL(a_ptr_bound, clk, rst_n, busy, ptr_reg <= count_reg)

endmodule

// ----- hdl/vdp_cmp.sv -----
// Vertex compare unit: one stored entry against the search key.
// Depends on vdp_pkg.
`timescale 1ns / 1ps

module vdp_cmp (
    input  vdp_pkg::vertex_t a,
    input  vdp_pkg::vertex_t b,
    output logic             eq
);

    // Eight float fields by IEEE rules, colour bitwise.
    always_comb
    begin
        eq = vdp_pkg::float_eq(a.nx, b.nx) && vdp_pkg::float_eq(a.ny, b.ny) &&
             vdp_pkg::float_eq(a.nz, b.nz) && vdp_pkg::float_eq(a.px, b.px) &&
             vdp_pkg::float_eq(a.py, b.py) && vdp_pkg::float_eq(a.pz, b.pz) &&
             vdp_pkg::float_eq(a.u, b.u) && vdp_pkg::float_eq(a.v, b.v) &&
             (a.col == b.col);
    end

endmodule
